### design/frsd_pkg.sv
// ----------------------------------------------------------------------------
// frsd_pkg
// Shared types, constants and helpers of the frequency rank decipher.
// ----------------------------------------------------------------------------
package frsd_pkg;

	localparam int COUNT_BITS  = 18;
	localparam int NUM_LETTERS = 26;
	localparam int LETTER_BITS = 5;
	localparam int CHAR_BITS   = 8;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	localparam logic [CHAR_BITS-1:0] CHAR_UPPER_A = 8'h41;
	localparam logic [CHAR_BITS-1:0] CHAR_UPPER_Z = 8'h5a;
	localparam logic [CHAR_BITS-1:0] CHAR_LOWER_A = 8'h61;
	localparam logic [CHAR_BITS-1:0] CHAR_LOWER_Z = 8'h7a;
	localparam logic [CHAR_BITS-1:0] CASE_OFFSET  = 8'h20;

	typedef enum logic [1:0] {
		ACT_CLEAR = 2'd0,
		ACT_LOAD  = 2'd1,
		ACT_COUNT = 2'd2,
		ACT_XLATE = 2'd3
	} action_t;

	typedef struct packed {
		logic clear_cnt;
		logic load_key;
		logic count_char;
		logic capture;
		logic emit;
	} frsd_cmd_t;

	typedef struct packed {
		logic                   is_letter;
		logic                   is_upper;
		logic [LETTER_BITS-1:0] idx;
	} letter_info_t;

	function automatic letter_info_t letter_info(input logic [CHAR_BITS-1:0] ch);
		letter_info_t info;
		logic [CHAR_BITS-1:0] diff;
		info = '0;
		diff = '0;
		if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
			diff = ch - CHAR_UPPER_A;
			info.is_letter = 1'b1;
			info.is_upper  = 1'b1;
		end else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
			diff = ch - CHAR_LOWER_A;
			info.is_letter = 1'b1;
		end
		info.idx = diff[LETTER_BITS-1:0];
		return info;
	endfunction

endpackage

### design/frsd_item_if.sv
// ----------------------------------------------------------------------------
// frsd_item_if
// Input channel of the decipher: action, character byte and key rank.
// ----------------------------------------------------------------------------
interface frsd_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] char_value;
	logic [4:0] key_rank;

	modport source (output valid, output action, output char_value, output key_rank,
		input ready);
	modport sink (input valid, input action, input char_value, input key_rank,
		output ready);
endinterface

### design/frsd_result_if.sv
// ----------------------------------------------------------------------------
// frsd_result_if
// Output channel of the decipher: one deciphered byte per beat.
// ----------------------------------------------------------------------------
interface frsd_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] plain_char;

	modport source (output valid, output plain_char, input ready);
	modport sink (input valid, input plain_char, output ready);
endinterface

### design/frsd_datapath.sv
// ----------------------------------------------------------------------------
// frsd_datapath
// Letter counters, key table, rank compare and result register.
// ----------------------------------------------------------------------------
module frsd_datapath
	import frsd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  frsd_cmd_t              cmd,
	input  logic [CHAR_BITS-1:0]   char_value,
	input  logic [LETTER_BITS-1:0] key_rank,
	output logic [CHAR_BITS-1:0]   plain_char
);

	logic [COUNT_BITS-1:0]  cnt_q [NUM_LETTERS];
	logic [CHAR_BITS-1:0]   key_q [NUM_LETTERS];

	logic [NUM_LETTERS-1:0] cmp_d;
	logic [NUM_LETTERS-1:0] cmp_s1;
	logic [CHAR_BITS-1:0]   char_s1;
	logic                   letter_s1;
	logic                   upper_s1;
	logic [CHAR_BITS-1:0]   plain_q;

	letter_info_t           info;
	logic [COUNT_BITS-1:0]  cur_cnt;
	logic [LETTER_BITS-1:0] rank;
	logic [CHAR_BITS-1:0]   key_char;
	logic [CHAR_BITS-1:0]   plain_d;

	assign info    = letter_info(char_value);
	assign cur_cnt = cnt_q[info.idx];

	// letter counters, saturating
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LETTERS; i++) cnt_q[i] <= '0;
		end else if (cmd.clear_cnt) begin
			for (int i = 0; i < NUM_LETTERS; i++) cnt_q[i] <= '0;
		end else if (cmd.count_char && info.is_letter && cur_cnt != COUNT_MAX) begin
			cnt_q[info.idx] <= cur_cnt + 1'b1;
		end
	end

	// key table
	always_ff @(posedge clk) begin
		if (cmd.load_key && key_rank < LETTER_BITS'(NUM_LETTERS)) begin
			key_q[key_rank] <= char_value;
		end
	end

	// one compare per letter against the current letter
	always_comb begin
		for (int j = 0; j < NUM_LETTERS; j++) begin
			cmp_d[j] = (cnt_q[j] < cur_cnt) ||
				(cnt_q[j] == cur_cnt && LETTER_BITS'(j) < info.idx);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmp_s1    <= cmp_d;
			char_s1   <= char_value;
			letter_s1 <= info.is_letter;
			upper_s1  <= info.is_upper;
		end
	end

	assign rank     = LETTER_BITS'($countones(cmp_s1));
	assign key_char = key_q[rank];

	always_comb begin
		if (!letter_s1) begin
			plain_d = char_s1;
		end else if (upper_s1) begin
			plain_d = key_char - CASE_OFFSET;
		end else begin
			plain_d = key_char;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			plain_q <= plain_d;
		end
	end

	assign plain_char = plain_q;

endmodule

### design/frsd_ctrl.sv
// ----------------------------------------------------------------------------
// frsd_ctrl
// Controller: decodes actions, sequences a translation, owns result valid.
// ----------------------------------------------------------------------------
module frsd_ctrl
	import frsd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	input  logic [1:0] item_action,
	output logic      item_ready,
	output logic      result_valid,
	input  logic      result_ready,
	output frsd_cmd_t cmd
);

	typedef enum logic {
		S_IDLE,
		S_RANK
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;

	assign item_ready   = (state_q == S_IDLE);
	assign accept       = item_valid && item_ready;
	assign result_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		if (accept) begin
			case (action_t'(item_action))
				ACT_CLEAR: cmd.clear_cnt  = 1'b1;
				ACT_LOAD:  cmd.load_key   = 1'b1;
				ACT_COUNT: cmd.count_char = 1'b1;
				ACT_XLATE: cmd.capture    = 1'b1;
				default:   cmd = '0;
			endcase
		end
		if (state_q == S_RANK && (!out_valid_q || result_ready)) begin
			cmd.emit = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd.capture) state_q <= S_RANK;
				end
				S_RANK: begin
					if (cmd.emit) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_xlate_enters_rank: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> state_q == S_RANK)
		else $error("translate beat did not start rank step");
	a_emit_in_rank: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> state_q == S_RANK)
		else $error("result written outside rank step");
	a_emit_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid_q && state_q == S_IDLE)
		else $error("result not presented after rank step");
	a_one_command: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clear_cnt, cmd.load_key, cmd.count_char, cmd.capture, cmd.emit}))
		else $error("more than one datapath command");
`endif

endmodule

### design/frequency_rank_substitution_decipher.sv
// ----------------------------------------------------------------------------
// frequency_rank_substitution_decipher
// Undoes a letter substitution by ranking letter frequencies.
//
// item channel: one beat per action. clear zeroes the 26 letter counters,
// load writes a key letter at a rank (ranks above 25 are dropped), count
// adds a case-folded letter to its saturating counter, translate returns
// the key letter at the letter's frequency rank (ties to the lower letter),
// keeping case; other bytes pass through.
// result channel: one beat per translate, carrying plain_char.
// clear, load and count complete when accepted and may follow back to back.
// A translate first registers the 26 counter compares when it is accepted;
// then the rank popcount and key read fill the result register, and
// plain_char is valid once that register is written.
// A new item is taken while a result still waits; a translate holds in its
// rank step while the result register is full and the receiver stalls.
// Reset clears the counters and the result valid; key letters must be
// loaded before they are used.
// ----------------------------------------------------------------------------
module frequency_rank_substitution_decipher
	import frsd_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	frsd_item_if.sink     item,
	frsd_result_if.source result
);

	frsd_cmd_t cmd;

	frsd_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_action  (item.action),
		.item_ready   (item.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.cmd          (cmd)
	);

	frsd_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.char_value (item.char_value),
		.key_rank   (item.key_rank),
		.plain_char (result.plain_char)
	);

endmodule
